FILE: hw/rtl/snf_pkg.sv
// ----------------------------------------------------------------------------
// Shelf next-fit placer package
// Widths, status codes, register indexes and the item/result bundles shared
// by the placer modules.
// ----------------------------------------------------------------------------
package snf_pkg;

   localparam int DIM_W     = 16;   // box and rectangle sides
   localparam int POS_W     = 17;   // cursor and shelf base
   localparam int AREA_W    = 32;   // full 16x16 product
   localparam int CSR_IDX_W = 8;    // configuration register index

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_HEIGHT = CSR_IDX_W'(1);

   // Placement status codes
   typedef enum logic [1:0] {
      ST_PLACED    = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_BOX_FULL  = 2'd2,
      ST_TOO_LARGE = 2'd3
   } status_type;

   // One rectangle after the input register, with its area precomputed
   typedef struct packed {
      logic [DIM_W-1:0]  rect_width;
      logic [DIM_W-1:0]  rect_height;
      logic [AREA_W-1:0] rect_area;
   } item_type;

   // One placement result
   typedef struct packed {
      status_type        status;
      logic              rotated;
      logic [POS_W-1:0]  cursor_x;
      logic [POS_W-1:0]  cursor_y;
   } result_type;

   // Box geometry handed from the register block to the placement core
   typedef struct packed {
      logic [DIM_W-1:0]  bin_width;
      logic [DIM_W-1:0]  bin_height;
      logic [AREA_W-1:0] box_area;
   } box_type;

endpackage

FILE: hw/rtl/snf_csr.sv
// ----------------------------------------------------------------------------
// Shelf next-fit configuration registers
// Holds the box width and height and keeps their product registered for the
// area check.
// ----------------------------------------------------------------------------
module snf_csr
   import snf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   output box_type              box
);

   logic [DIM_W-1:0]  bin_width_ff;
   logic [DIM_W-1:0]  bin_height_ff;
   logic [DIM_W-1:0]  bin_width_in;
   logic [DIM_W-1:0]  bin_height_in;
   logic [AREA_W-1:0] box_area_ff;
   logic [AREA_W-1:0] box_area_in;

   // Writes always taken
   assign csr_ready = 1'b1;

   // Next register values; unknown indexes are dropped
   always_comb begin
      bin_width_in  = bin_width_ff;
      bin_height_in = bin_height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BIN_WIDTH:  bin_width_in  = csr_wdata;
            CSR_BIN_HEIGHT: bin_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Box area taken from the new sizes, so it changes on the same edge as they do
   assign box_area_in = {{(AREA_W-DIM_W){1'b0}}, bin_width_in}
                      * {{(AREA_W-DIM_W){1'b0}}, bin_height_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff  <= '0;
         bin_height_ff <= '0;
         box_area_ff   <= '0;
      end else begin
         bin_width_ff  <= bin_width_in;
         bin_height_ff <= bin_height_in;
         box_area_ff   <= box_area_in;
      end
   end

   assign box.bin_width  = bin_width_ff;
   assign box.bin_height = bin_height_ff;
   assign box.box_area   = box_area_ff;

endmodule

FILE: hw/rtl/snf_shelf_core.sv
// ----------------------------------------------------------------------------
// Shelf next-fit placement core
// Holds the cursor, shelf base and shelf height, works out the placement of
// one item combinationally and commits the new shelf state on a step.
// ----------------------------------------------------------------------------
module snf_shelf_core
   import snf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  box_type    box,
   output result_type result
);

   logic [POS_W-1:0] cursor_x_ff, cursor_x_in;
   logic [POS_W-1:0] base_y_ff, base_y_in;
   logic [DIM_W-1:0] shelf_h_ff, shelf_h_in;

   logic [POS_W:0]   x_plus_w;
   logic [POS_W:0]   base_plus_sh;
   logic             too_large;
   logic             box_full;
   logic             advance;
   logic [POS_W-1:0] x1;
   logic [POS_W-1:0] y1;
   logic [DIM_W-1:0] sh1;
   logic [POS_W:0]   y1_plus_h;
   logic [POS_W:0]   y1_plus_hi;
   logic [POS_W:0]   x1_plus_hi;
   logic [POS_W:0]   x1_plus_lo;
   logic [POS_W:0]   x1_plus_w;
   logic [DIM_W-1:0] lo;
   logic [DIM_W-1:0] hi;
   logic             turn;
   logic             fits_h;
   logic             upright_ok;

   // Shelf advance test and the state after a possible advance
   assign x_plus_w     = {1'b0, cursor_x_ff} + {2'b0, item.rect_width};
   assign base_plus_sh = {1'b0, base_y_ff} + {2'b0, shelf_h_ff};
   assign advance      = x_plus_w > {2'b0, box.bin_width};
   assign x1  = advance ? '0 : cursor_x_ff;
   assign y1  = advance ? base_plus_sh[POS_W-1:0] : base_y_ff;
   assign sh1 = advance ? '0 : shelf_h_ff;

   // Early outs
   assign too_large = item.rect_area > box.box_area;
   assign box_full  = base_y_ff >= {1'b0, box.bin_height};

   // Long and short side of the rectangle
   assign turn = item.rect_height < item.rect_width;
   assign lo   = turn ? item.rect_height : item.rect_width;
   assign hi   = turn ? item.rect_width  : item.rect_height;

   assign y1_plus_h  = {1'b0, y1} + {2'b0, item.rect_height};
   assign y1_plus_hi = {1'b0, y1} + {2'b0, hi};
   assign x1_plus_hi = {1'b0, x1} + {2'b0, hi};
   assign x1_plus_lo = {1'b0, x1} + {2'b0, lo};
   assign x1_plus_w  = {1'b0, x1} + {2'b0, item.rect_width};
   assign fits_h     = y1_plus_h <= {2'b0, box.bin_height};
   assign upright_ok = (y1_plus_hi <= {2'b0, box.bin_height})
                    && (x1_plus_hi <= {2'b0, box.bin_width});

   // Placement decision and next shelf state
   always_comb begin
      cursor_x_in    = cursor_x_ff;
      base_y_in      = base_y_ff;
      shelf_h_in     = shelf_h_ff;
      result.status  = ST_PLACED;
      result.rotated = 1'b0;
      if (too_large) begin
         result.status = ST_TOO_LARGE;
      end else if (box_full) begin
         result.status = ST_BOX_FULL;
      end else if (!fits_h) begin
         // shelf advance is kept even though the item fails
         result.status = ST_NO_FIT;
         cursor_x_in   = x1;
         base_y_in     = y1;
         shelf_h_in    = sh1;
      end else begin
         base_y_in = y1;
         if (sh1 == '0) begin
            // first on the shelf: short side sets the shelf height
            shelf_h_in     = lo;
            cursor_x_in    = x1_plus_hi[POS_W-1:0];
            result.rotated = turn;
         end else if (upright_ok) begin
            shelf_h_in     = (sh1 > hi) ? sh1 : hi;
            cursor_x_in    = x1_plus_lo[POS_W-1:0];
            result.rotated = turn;
         end else begin
            shelf_h_in  = (sh1 > item.rect_height) ? sh1 : item.rect_height;
            cursor_x_in = x1_plus_w[POS_W-1:0];
         end
      end
      result.cursor_x = cursor_x_in;
      result.cursor_y = base_y_in;
   end

   // Shelf state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         base_y_ff   <= '0;
         shelf_h_ff  <= '0;
      end else if (step) begin
         cursor_x_ff <= cursor_x_in;
         base_y_ff   <= base_y_in;
         shelf_h_ff  <= shelf_h_in;
      end
   end

endmodule

FILE: hw/rtl/shelf_next_fit_placer.sv
// ----------------------------------------------------------------------------
// Shelf next-fit placer
// Places rectangles left to right on shelves inside a configured box and
// reports status, turn and the cursor after each item.
// ----------------------------------------------------------------------------
// Pipeline: input register holding the rectangle area, placement logic, then
// the result register. Throughput: 1 item per cycle unless rsp_ready stalls
// the result; shelf state is fed back to the placement of the next item.
// Reset: synchronous, clears shelf state, box size and both pipeline valids.
// ----------------------------------------------------------------------------
module shelf_next_fit_placer
   import snf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   // rectangle items
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DIM_W-1:0]     req_rect_width,
   input  logic [DIM_W-1:0]     req_rect_height,
   // results
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic                 rsp_rotated,
   output logic [POS_W-1:0]     rsp_cursor_x,
   output logic [POS_W-1:0]     rsp_cursor_y
);

   box_type    box;
   item_type   item_ff, item_in;
   logic       item_valid_ff;
   result_type result_in, result_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       step;
   logic       req_take;

   // Configuration registers
   snf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .box       (box)
   );

   // Pipeline flow
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   // Input register with rectangle area
   assign item_in.rect_width  = req_rect_width;
   assign item_in.rect_height = req_rect_height;
   assign item_in.rect_area   = {{(AREA_W-DIM_W){1'b0}}, req_rect_width}
                              * {{(AREA_W-DIM_W){1'b0}}, req_rect_height};

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // Placement and shelf state
   snf_shelf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .box    (box),
      .result (result_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = result_ff.status;
   assign rsp_rotated  = result_ff.rotated;
   assign rsp_cursor_x = result_ff.cursor_x;
   assign rsp_cursor_y = result_ff.cursor_y;

endmodule
